[rtl/asrf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_pkg
// Shared types, constants and the sample conversion for the audio ring FIFO.
// ----------------------------------------------------------------------------
package asrf_pkg;

    localparam int RING_BYTES      = 4096;
    localparam int PTR_W           = $clog2(RING_BYTES);
    localparam int CNT_W           = PTR_W + 1;
    localparam int MAX_READ_FRAMES = 32;
    localparam int STALL_W         = 17;
    localparam int QB_W            = 13;
    localparam int QF_W            = 11;
    localparam int LEFT_W          = 7;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_DELAY = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_PAUSE = 3'd4;
    localparam logic [2:0] MODE_CLOSE = 3'd5;

    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic [15:0] LIMIT_RESET = 16'd250;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_READ,
        OP_DELAY,
        OP_CLEAR,
        OP_PAUSE,
        OP_CLOSE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data_byte;
        logic [5:0]  frame_limit;
        logic [15:0] delay_ms;
        logic        pause_req;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_FETCH,
        S_WAIT,
        S_EMIT
    } t_state;

    // Signed 16-bit sample scaled by 2^-15, as IEEE single bits. Always exact.
    function automatic logic [31:0] s16_to_f32(input logic [15:0] raw);
        logic        sgn;
        logic [15:0] mag;
        logic [3:0]  pos;
        logic [15:0] norm;
        logic [7:0]  expo;
        sgn  = raw[15];
        mag  = sgn ? (~raw + 16'd1) : raw;
        pos  = '0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) begin
                pos = 4'(i);
            end
        end
        norm = mag << (4'd15 - pos);
        expo = 8'd112 + {4'd0, pos};
        if (mag == '0) begin
            return 32'd0;
        end
        return {sgn, expo, norm[14:0], 8'd0};
    endfunction

endpackage

[rtl/audio_sample_ring_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_ring_fifo
// Overwriting 4096-byte ring FIFO for stereo audio with sample unpacking.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one transaction per command; a
// two-entry command queue lets the input run ahead of the executor.
// Output channel (o_out_valid / i_out_stall): one transaction per result;
// o_last marks the final result of a command. A read popping n > 0 frames
// gives 2n samples, left then right; every other command gives one result.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 sample format, index 1
// stall limit; ready is always high, write only while the block is idle.
// A non-read command goes from the queue through S_ONE to the result
// register; the next command is taken only after that. A read decodes in
// S_IDLE, then each popped sample reads its bytes (two for s16, four for f32)
// one per cycle from the single RAM read port, then passes S_WAIT and S_EMIT.
// Reset empties the ring, sets pause and clears the stall count. The ring
// memory itself is not cleared. When the receiver stalls, the held result
// stays put and the executor waits; the queue then fills and stalls input.
module audio_sample_ring_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [19:0] i_chunk_len,
    input  logic [5:0]  i_frame_limit,
    input  logic [15:0] i_delay_ms,
    input  logic        i_pause_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_sample_bits,
    output logic        o_sample_valid,
    output logic        o_channel,
    output logic [5:0]  o_frames_returned,
    output logic [12:0] o_queued_bytes,
    output logic [10:0] o_queued_frames,
    output logic        o_stall_cleared,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import asrf_pkg::*;

    logic        r_fmt;
    logic [15:0] r_limit;
    logic        cmd_valid;
    t_cmd        cmd;
    logic        cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FORMAT: r_fmt   <= i_cfg_data[0];
                REG_LIMIT:  r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    asrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_data_byte   (i_data_byte),
        .i_chunk_len   (i_chunk_len),
        .i_frame_limit (i_frame_limit),
        .i_delay_ms    (i_delay_ms),
        .i_pause_req   (i_pause_req),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    asrf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fmt             (r_fmt),
        .i_limit           (r_limit),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sample_bits     (o_sample_bits),
        .o_sample_valid    (o_sample_valid),
        .o_channel         (o_channel),
        .o_frames_returned (o_frames_returned),
        .o_queued_bytes    (o_queued_bytes),
        .o_queued_frames   (o_queued_frames),
        .o_stall_cleared   (o_stall_cleared),
        .o_last            (o_last)
    );
endmodule

[rtl/asrf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/asrf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_front
// Accepts input transactions, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module asrf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [2:0]    i_mode,
    input  logic [7:0]    i_data_byte,
    input  logic [19:0]   i_chunk_len,
    input  logic [5:0]    i_frame_limit,
    input  logic [15:0]   i_delay_ms,
    input  logic          i_pause_req,
    output logic          o_cmd_valid,
    output asrf_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import asrf_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        n_cmd.data_byte   = i_data_byte;
        n_cmd.delay_ms    = i_delay_ms;
        n_cmd.pause_req   = i_pause_req;
        n_cmd.frame_limit = (i_frame_limit > 6'(MAX_READ_FRAMES)) ?
                            6'(MAX_READ_FRAMES) : i_frame_limit;
        unique case (i_mode)
            MODE_WRITE: n_cmd.op = (i_chunk_len != '0 &&
                                    i_chunk_len <= 20'(RING_BYTES)) ? OP_WRITE : OP_NOP;
            MODE_READ:  n_cmd.op = OP_READ;
            MODE_DELAY: n_cmd.op = OP_DELAY;
            MODE_CLEAR: n_cmd.op = OP_CLEAR;
            MODE_PAUSE: n_cmd.op = OP_PAUSE;
            MODE_CLOSE: n_cmd.op = OP_CLOSE;
            default:    n_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("command queue overfilled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && r_cnt == 2'd1) |=> (r_cnt == 2'd2))
        else $error("queue count lost a push");
endmodule

[rtl/asrf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrf_back
// Executes queued commands on the ring and drives the result register.
// ----------------------------------------------------------------------------
module asrf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fmt,
    input  logic [15:0]    i_limit,
    input  logic           i_cmd_valid,
    input  asrf_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [31:0]    o_sample_bits,
    output logic           o_sample_valid,
    output logic           o_channel,
    output logic [5:0]     o_frames_returned,
    output logic [12:0]    o_queued_bytes,
    output logic [10:0]    o_queued_frames,
    output logic           o_stall_cleared,
    output logic           o_last
);
    import asrf_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               r_paused;
    logic [STALL_W-1:0] r_stall;
    logic [5:0]         r_frames;
    logic               r_cleared;
    logic [LEFT_W-1:0]  r_left;
    logic               r_chan;
    logic [1:0]         r_bidx;
    logic               r_cap_pend;
    logic [1:0]         r_cap_idx;
    logic [31:0]        r_word;
    logic               r_out_valid;
    logic [31:0]        r_sample_bits;
    logic               r_sample_valid;
    logic               r_channel;
    logic [5:0]         r_frames_ret;
    logic [12:0]        r_qbytes;
    logic [10:0]        r_qframes;
    logic               r_scleared;
    logic               r_last;

    logic               out_free;
    logic               start;
    logic               issue;
    logic               load_one;
    logic               load_smp;
    logic [1:0]         shift;
    logic [1:0]         last_byte;
    logic [10:0]        avail;
    logic [5:0]         frames;
    logic [CNT_W-1:0]   read_bytes;
    logic [STALL_W:0]   stall_sum;
    logic [STALL_W-1:0] stall_sat;
    logic               full;
    logic [PTR_W-1:0]   waddr;
    logic               we;
    logic [7:0]         rdata;

    assign shift      = i_fmt ? 2'd3 : 2'd2;
    assign last_byte  = i_fmt ? 2'd3 : 2'd1;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign avail      = 11'(r_count >> shift);
    assign frames     = (r_paused || i_cmd.op != OP_READ) ? 6'd0 :
                        ((avail < 11'(i_cmd.frame_limit)) ? 6'(avail) : i_cmd.frame_limit);
    assign read_bytes = CNT_W'(frames) << shift;
    assign stall_sum  = {1'b0, r_stall} + (STALL_W + 1)'(i_cmd.delay_ms);
    assign stall_sat  = stall_sum[STALL_W] ? '1 : stall_sum[STALL_W-1:0];
    assign full       = (r_count >= CNT_W'(RING_BYTES));
    assign waddr      = full ? r_rd_ptr : PTR_W'(r_rd_ptr + r_count[PTR_W-1:0]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_cmd_valid) n_state = (frames != '0) ? S_FETCH : S_ONE;
            S_ONE:   if (out_free) n_state = S_IDLE;
            S_FETCH: if (r_bidx == last_byte) n_state = S_WAIT;
            S_WAIT:  n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = (r_left == LEFT_W'(1)) ? S_IDLE : S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        start    = 1'b0;
        issue    = 1'b0;
        load_one = 1'b0;
        load_smp = 1'b0;
        unique case (r_state)
            S_IDLE:  start    = i_cmd_valid;
            S_ONE:   load_one = out_free;
            S_FETCH: issue    = 1'b1;
            S_WAIT:  ;
            S_EMIT:  load_smp = out_free;
            default: ;
        endcase
    end

    assign o_cmd_pop = start;
    assign we        = start && (i_cmd.op == OP_WRITE);

    asrf_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.data_byte),
        .i_re    (issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (r_cap_pend) begin
            r_word[8*r_cap_idx +: 8] <= rdata;
        end
        r_cap_idx <= r_bidx;
        if (load_one || load_smp) begin
            r_sample_bits  <= load_smp ? (i_fmt ? r_word : s16_to_f32(r_word[15:0])) : '0;
            r_sample_valid <= load_smp;
            r_channel      <= load_smp && r_chan;
            r_frames_ret   <= r_frames;
            r_qbytes       <= QB_W'(r_count);
            r_qframes      <= QF_W'(r_count >> shift);
            r_scleared     <= r_cleared;
            r_last         <= load_one || (r_left == LEFT_W'(1));
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_paused    <= 1'b1;
            r_stall     <= '0;
            r_frames    <= '0;
            r_cleared   <= 1'b0;
            r_left      <= '0;
            r_chan      <= 1'b0;
            r_bidx      <= '0;
            r_cap_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cap_pend <= issue;
            if (start) begin
                r_frames  <= frames;
                r_cleared <= 1'b0;
                r_left    <= LEFT_W'({frames, 1'b0});
                r_chan    <= 1'b0;
                r_bidx    <= '0;
                case (i_cmd.op)
                    OP_WRITE: begin
                        if (full) begin
                            r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    OP_READ: begin
                        r_count <= r_count - read_bytes;
                        if (frames != '0) begin
                            r_stall <= '0;
                        end
                    end
                    OP_DELAY: begin
                        if (stall_sat >= STALL_W'(i_limit)) begin
                            r_rd_ptr  <= '0;
                            r_count   <= '0;
                            r_stall   <= '0;
                            r_cleared <= 1'b1;
                        end else begin
                            r_stall <= stall_sat;
                        end
                    end
                    OP_CLEAR: begin
                        r_rd_ptr <= '0;
                        r_count  <= '0;
                    end
                    OP_PAUSE: r_paused <= i_cmd.pause_req;
                    OP_CLOSE: begin
                        r_rd_ptr <= '0;
                        r_count  <= '0;
                        r_paused <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (issue) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                r_bidx   <= r_bidx + 2'd1;
            end
            if (load_smp) begin
                r_left <= r_left - LEFT_W'(1);
                r_chan <= ~r_chan;
                r_bidx <= '0;
            end
            if (load_one || load_smp) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_bits     = r_sample_bits;
    assign o_sample_valid    = r_sample_valid;
    assign o_channel         = r_channel;
    assign o_frames_returned = r_frames_ret;
    assign o_queued_bytes    = r_qbytes;
    assign o_queued_frames   = r_qframes;
    assign o_stall_cleared   = r_scleared;
    assign o_last            = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_BYTES)) else $error("byte count above ring size");
    a_fetch_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH || r_state == S_EMIT) |-> (r_left != '0))
        else $error("sample fetch with no samples left");
    a_cap_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_pend |-> $past(issue)) else $error("capture without a read");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_one || load_smp) |-> out_free) else $error("result register overwritten");
endmodule
